>>> rtl/laplacian_5x5_edge_filter_assert.svh
// assertion macros for the laplacian 5x5 edge filter
// expects clk and rst_n in the scope where a macro is used
`ifndef LAPLACIAN_5X5_EDGE_FILTER_ASSERT_SVH
`define LAPLACIAN_5X5_EDGE_FILTER_ASSERT_SVH

// same-cycle implication
`define LAP5_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lap5 assertion failed");

// next-cycle implication
`define LAP5_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lap5 assertion failed");

`endif

>>> rtl/lap5_pkg.sv
// shared types and constants for the laplacian 5x5 edge filter
// no dependencies
package lap5_pkg;

    localparam int PIX_W          = 8;
    localparam int OUT_COL_W      = 11;
    localparam int OUT_ROW_W      = 12;
    localparam int LINE_WIDTH_W   = 12;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;

    localparam int LINES          = 4;
    localparam int WIN            = 5;
    localparam int MID_LINE       = 1;
    localparam int CENTRE_OFS     = 2;
    localparam int EMIT_MIN       = 4;
    localparam int MIN_SIZE       = 6;
    localparam int CENTRE_WEIGHT  = 25;
    localparam int PIX_MAX        = 255;
    localparam int COLSUM_W       = 11;
    localparam int SUM_W          = 13;

    localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 12'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic emit;
        logic done;
    } pos_flags_t;

    typedef struct packed {
        logic [PIX_W-1:0]     filtered_pixel;
        logic [OUT_COL_W-1:0] out_col;
        logic [OUT_ROW_W-1:0] out_row;
        logic                 frame_done;
    } res_t;

endpackage

>>> rtl/lap5_pos.sv
// frame geometry registers and raster position counters
// depends on lap5_pkg
module lap5_pos #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lap5_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lap5_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                step,
    output logic [$clog2(MAX_WIDTH)-1:0]        col,
    output logic [$clog2(MAX_HEIGHT)-1:0]       row,
    output lap5_pkg::pos_flags_t                flags
);
    import lap5_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = (CW + 1 > LINE_WIDTH_W) ? CW + 1 : LINE_WIDTH_W;
    localparam int HEW = (RW + 1 > FRAME_HEIGHT_W) ? RW + 1 : FRAME_HEIGHT_W;

    logic [LINE_WIDTH_W-1:0]   line_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [CW-1:0]             col_count_reg;
    logic [CW-1:0]             col_count_next;
    logic [RW-1:0]             row_count_reg;
    logic [RW-1:0]             row_count_next;

    logic [WEW-1:0] w_raw;
    logic [WEW-1:0] w_eff;
    logic [HEW-1:0] h_raw;
    logic [HEW-1:0] h_eff;
    logic [RW:0]    row_pre;
    logic [CW-1:0]  col_cur;
    logic [RW-1:0]  row_cur;
    logic [WEW-1:0] col_inc;
    logic [HEW-1:0] row_inc;

    always_comb
    begin
        w_raw = WEW'(line_width_reg);
        if (w_raw < WEW'(MIN_SIZE))
            w_eff = WEW'(MIN_SIZE);
        else if (w_raw > WEW'(MAX_WIDTH))
            w_eff = WEW'(MAX_WIDTH);
        else
            w_eff = w_raw;

        h_raw = HEW'(frame_height_reg);
        if (h_raw < HEW'(MIN_SIZE))
            h_eff = HEW'(MIN_SIZE);
        else if (h_raw > HEW'(MAX_HEIGHT))
            h_eff = HEW'(MAX_HEIGHT);
        else
            h_eff = h_raw;

        // wrap before use if the geometry shrank under the counters
        col_cur = col_count_reg;
        row_pre = {1'b0, row_count_reg};
        if (WEW'(col_count_reg) >= w_eff)
        begin
            col_cur = '0;
            row_pre = row_pre + (RW+1)'(1);
        end
        if (HEW'(row_pre) >= h_eff)
            row_cur = '0;
        else
            row_cur = row_pre[RW-1:0];

        col_inc        = WEW'(col_cur) + WEW'(1);
        row_inc        = HEW'(row_cur) + HEW'(1);
        col_count_next = CW'(col_inc);
        row_count_next = row_cur;
        if (col_inc >= w_eff)
        begin
            col_count_next = '0;
            if (row_inc >= h_eff)
                row_count_next = '0;
            else
                row_count_next = RW'(row_inc);
        end
    end

    assign col        = col_cur;
    assign row        = row_cur;
    assign flags.emit = (col_cur >= CW'(EMIT_MIN)) && (row_cur >= RW'(EMIT_MIN));
    assign flags.done = (WEW'(col_cur) == w_eff - WEW'(1)) && (HEW'(row_cur) == h_eff - HEW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LINE_WIDTH:   line_width_reg   <= cfg_data[LINE_WIDTH_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_HEIGHT_W-1:0];
                    default:          line_width_reg   <= line_width_reg;
                endcase
            end
            if (step)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
        end
    end

endmodule

>>> rtl/lap5_skid.sv
// two-entry output buffer: output register plus skid register
// depends on lap5_pkg
module lap5_skid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lap5_pkg::res_t push_data,
    output logic           full,
    output logic           out_valid,
    input  logic           out_stall,
    output lap5_pkg::res_t out_data
);
    import lap5_pkg::*;

    logic out_valid_reg;
    res_t out_reg;
    logic skid_valid_reg;
    res_t skid_reg;
    logic take;

    assign take      = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_reg <= push;
            out_reg       <= push_data;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
            skid_reg       <= push_data;
        end
    end

endmodule

>>> rtl/laplacian_5x5_edge_filter.sv
// laplacian 5x5 edge filter, top level: line memory, window and arithmetic pipeline
// depends on lap5_pkg, lap5_pos, lap5_skid and laplacian_5x5_edge_filter_assert.svh
//
// pixels enter in raster order on pixel_in, one transaction per in_valid high with
// in_stall low. results leave on filtered_pixel/out_col/out_row/frame_done, one
// transaction per out_valid high with out_stall low. only interior centres give a
// result; border pixels give none. frame_done marks the last interior result.
// line_width and frame_height are written through cfg_we/cfg_index/cfg_data while idle;
// the block does not enforce that, the user must. throughput: one pixel per cycle while
// not stalled, set by the single line memory access per pixel (one read of the four stored
// lines at a column into rd_data_reg, written back from the s1 registers).
// a stalled output parks in the output register and a skid register; input stalls
// only when both are occupied, and resumes the cycle after the skid drains.
// reset clears counters, geometry (640 x 480) and handshake state; the line memory
// needs no clearing pass, the first four rows of each frame fill it.
module laplacian_5x5_edge_filter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lap5_pkg::PIX_W-1:0]          pixel_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lap5_pkg::PIX_W-1:0]          filtered_pixel,
    output logic [lap5_pkg::OUT_COL_W-1:0]      out_col,
    output logic [lap5_pkg::OUT_ROW_W-1:0]      out_row,
    output logic                                frame_done,
    input  logic                                cfg_we,
    input  logic [lap5_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lap5_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lap5_pkg::*;
    `include "laplacian_5x5_edge_filter_assert.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int MW = LINES * PIX_W;

    logic       adv;
    logic       in_acc;
    logic       skid_full;
    logic       res_push;
    res_t       res;
    res_t       out_res;

    logic [CW-1:0] pos_col;
    logic [RW-1:0] pos_row;
    pos_flags_t    pos_flags;

    logic [MW-1:0] line_mem [MAX_WIDTH];
    logic [MW-1:0] rd_data_reg;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [RW-1:0]    s1_row_reg;
    pos_flags_t       s1_flags_reg;

    logic [COLSUM_W-1:0] new_colsum;
    logic [COLSUM_W-1:0] colsum_reg [WIN];
    logic [PIX_W-1:0]    mid_reg [3];

    logic                 s2_valid_reg;
    logic [OUT_COL_W-1:0] s2_col_reg;
    logic [OUT_ROW_W-1:0] s2_row_reg;
    logic                 s2_done_reg;

    logic                 s3_valid_reg;
    logic [SUM_W-1:0]     total_reg;
    logic [SUM_W-1:0]     c25_reg;
    logic [OUT_COL_W-1:0] s3_col_reg;
    logic [OUT_ROW_W-1:0] s3_row_reg;
    logic                 s3_done_reg;

    logic [SUM_W-1:0]        total_next;
    logic signed [SUM_W:0]   diff;

    assign adv      = !skid_full;
    assign in_stall = !adv;
    assign in_acc   = in_valid && adv;

    lap5_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (in_acc),
        .col       (pos_col),
        .row       (pos_row),
        .flags     (pos_flags)
    );

    // line memory: one word per column, byte k holds the row k+1 lines up
    always_ff @(posedge clk)
    begin
        if (adv)
            rd_data_reg <= line_mem[pos_col];
        if (s1_valid_reg && adv)
            line_mem[s1_col_reg] <= {rd_data_reg[MW-PIX_W-1:0], s1_px_reg};
    end

    always_comb
    begin
        new_colsum = COLSUM_W'(s1_px_reg);
        for (int k = 0; k < LINES; k++)
            new_colsum = new_colsum + COLSUM_W'(rd_data_reg[k*PIX_W +: PIX_W]);
    end

    always_comb
    begin
        total_next = '0;
        for (int j = 0; j < WIN; j++)
            total_next = total_next + SUM_W'(colsum_reg[j]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg && s1_flags_reg.emit;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg    <= pixel_in;
            s1_col_reg   <= pos_col;
            s1_row_reg   <= pos_row;
            s1_flags_reg <= pos_flags;

            // window shift: column sums and the middle row
            if (s1_valid_reg)
            begin
                for (int j = 0; j < WIN - 1; j++)
                    colsum_reg[j] <= colsum_reg[j+1];
                colsum_reg[WIN-1] <= new_colsum;
                mid_reg[0] <= mid_reg[1];
                mid_reg[1] <= mid_reg[2];
                mid_reg[2] <= rd_data_reg[MID_LINE*PIX_W +: PIX_W];
            end
            s2_col_reg  <= OUT_COL_W'(s1_col_reg - CW'(CENTRE_OFS));
            s2_row_reg  <= OUT_ROW_W'(s1_row_reg - RW'(CENTRE_OFS));
            s2_done_reg <= s1_flags_reg.done;

            total_reg   <= total_next;
            c25_reg     <= SUM_W'(mid_reg[0]) * SUM_W'(CENTRE_WEIGHT);
            s3_col_reg  <= s2_col_reg;
            s3_row_reg  <= s2_row_reg;
            s3_done_reg <= s2_done_reg;
        end
    end

    always_comb
    begin
        diff = $signed({1'b0, c25_reg}) - $signed({1'b0, total_reg});
        if (diff < 0)
            res.filtered_pixel = '0;
        else if (diff > (SUM_W+1)'(PIX_MAX))
            res.filtered_pixel = PIX_W'(PIX_MAX);
        else
            res.filtered_pixel = diff[PIX_W-1:0];
        res.out_col    = s3_col_reg;
        res.out_row    = s3_row_reg;
        res.frame_done = s3_done_reg;
    end

    assign res_push = s3_valid_reg && adv;

    lap5_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign filtered_pixel = out_res.filtered_pixel;
    assign out_col        = out_res.out_col;
    assign out_row        = out_res.out_row;
    assign frame_done     = out_res.frame_done;

    // the write-back and the next read never hit the same column
    `LAP5_ASSERT_IMP(a_no_rmw_overlap, in_acc && s1_valid_reg, pos_col != s1_col_reg)
    // no result is pushed into a full output buffer
    `LAP5_ASSERT_IMP(a_no_push_full, s3_valid_reg && skid_full, !res_push)
    // read data holds while the pipeline is frozen
    `LAP5_ASSERT_NXT(a_rd_hold, s1_valid_reg && !adv, $stable(rd_data_reg))

endmodule
